/* rtl/e2c_pkg.sv */
// ---------------------------------------------------------------------------
// e2c_pkg
// Shared widths, constants and calendar tables for the epoch-seconds
// to calendar converter.
// ---------------------------------------------------------------------------
package e2c_pkg;

	localparam int SECS_W   = 33;
	localparam int DAYS_W   = 16;
	localparam int REM_W    = 17;
	localparam int YEAR_W   = 8;
	localparam int MON_W    = 4;
	localparam int MDAY_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int WDAY_W   = 3;
	localparam int YDAY_W   = 9;
	localparam int YIDX_W   = 8;

	// first second of 2100-01-01
	localparam logic [SECS_W-1:0] END_SECONDS = 33'd4102444800;

	// 86400 = 2^7 * 675; the odd factor is handled by reciprocal multiply
	localparam int               DAY_LO_W    = 7;
	localparam int               DAY_X_W     = 25;
	localparam int               DAY_SHIFT   = 25;
	localparam logic [15:0]      DAY_RECIP   = 16'd49710;
	localparam logic [9:0]       DAY_ODD     = 10'd675;

	localparam int               MIN_SHIFT   = 17;
	localparam logic [11:0]      MIN_RECIP   = 12'd2184;
	localparam int               HR_SHIFT    = 11;
	localparam logic [5:0]       HR_RECIP    = 6'd34;
	localparam logic [6:0]       SIXTY       = 7'd60;

	localparam int               YR_SHIFT    = 18;
	localparam logic [7:0]       YR_RECIP    = 8'd179;
	localparam int               WK_SHIFT    = 16;
	localparam logic [13:0]      WK_RECIP    = 14'd9362;
	localparam logic [3:0]       DAYS_WEEK   = 4'd7;
	localparam logic [DAYS_W-1:0] EPOCH_WDAY = 16'd4;
	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 8'd70;

	typedef struct packed {
		logic vld;
		logic oor;
	} ctl_t;

	// first day (since epoch) of year 1970+idx; valid up to idx 130
	function automatic logic [DAYS_W-1:0] year_start(input logic [YIDX_W-1:0] idx);
		logic [YIDX_W:0] nx;
		nx = {1'b0, idx} + 9'd1;
		return DAYS_W'(idx) * 16'd365 + DAYS_W'(nx >> 2);
	endfunction

	// day of year on which month m begins
	function automatic logic [YDAY_W-1:0] month_start(input logic [MON_W-1:0] m,
							  input logic leap);
		logic [YDAY_W-1:0] base;
		case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (m inside {[4'd2:4'd11]}))
			base = base + 9'd1;
		return base;
	endfunction

endpackage

/* rtl/epoch_seconds_to_calendar.sv */
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Pipeline: 8 register stages from input beat to result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits on out_stall, set by the single output stage.
// Reset: arst_n clears the stage valid and out-of-range bits only; no datapath state.
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [e2c_pkg::SECS_W-1:0]    epoch_seconds,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [e2c_pkg::YEAR_W-1:0]    years_since_1900,
	output logic [e2c_pkg::MON_W-1:0]     month_index,
	output logic [e2c_pkg::MDAY_W-1:0]    day_of_month,
	output logic [e2c_pkg::HOUR_W-1:0]    hour_of_day,
	output logic [e2c_pkg::MIN_W-1:0]     minute_of_hour,
	output logic [e2c_pkg::SEC_W-1:0]     second_of_minute,
	output logic [e2c_pkg::WDAY_W-1:0]    weekday,
	output logic [e2c_pkg::YDAY_W-1:0]    day_of_year,
	output logic                          out_of_range
);
	import e2c_pkg::*;

	logic                 adv;
	logic [SECS_W-1:0]    secs_s1;
	ctl_t                 ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	ctl_t                 ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic [DAYS_W-1:0]    days;
	logic [REM_W-1:0]     rem;
	logic [HOUR_W-1:0]    hour;
	logic [MIN_W-1:0]     minute;
	logic [SEC_W-1:0]     second;
	logic [YEAR_W-1:0]    year;
	logic [MON_W-1:0]     month;
	logic [MDAY_W-1:0]    mday;
	logic [WDAY_W-1:0]    wday;
	logic [YDAY_W-1:0]    yday;
	logic                 keep;

	// pipeline moves unless the last stage holds a beat that is stalled
	assign adv      = !(ctl_s8.vld && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{vld: in_valid, oor: (epoch_seconds >= END_SECONDS)};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			secs_s1 <= epoch_seconds;
	end

	e2c_day_div u_day_div (
		.clk  (clk),
		.en   (adv),
		.secs (secs_s1),
		.days (days),
		.rem  (rem)
	);

	e2c_tod u_tod (
		.clk    (clk),
		.en     (adv),
		.rem    (rem),
		.hour   (hour),
		.minute (minute),
		.second (second)
	);

	e2c_date u_date (
		.clk   (clk),
		.en    (adv),
		.days  (days),
		.year  (year),
		.month (month),
		.mday  (mday),
		.wday  (wday),
		.yday  (yday)
	);

	// out-of-range beats report zero in every calendar field
	assign keep             = !ctl_s8.oor;
	assign out_valid        = ctl_s8.vld;
	assign out_of_range     = ctl_s8.oor;
	assign years_since_1900 = keep ? year   : '0;
	assign month_index      = keep ? month  : '0;
	assign day_of_month     = keep ? mday   : '0;
	assign hour_of_day      = keep ? hour   : '0;
	assign minute_of_hour   = keep ? minute : '0;
	assign second_of_minute = keep ? second : '0;
	assign weekday          = keep ? wday   : '0;
	assign day_of_year      = keep ? yday   : '0;

endmodule

/* rtl/e2c_day_div.sv */
// ---------------------------------------------------------------------------
// e2c_day_div
// Splits a second count into whole days and seconds of the day over three
// pipeline stages: reciprocal multiply, back-multiply, one-step correction.
// ---------------------------------------------------------------------------
module e2c_day_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [e2c_pkg::SECS_W-1:0]    secs,
	output logic [e2c_pkg::DAYS_W-1:0]    days,
	output logic [e2c_pkg::REM_W-1:0]     rem
);
	import e2c_pkg::*;

	logic [DAY_X_W-1:0]      x_s2, x_s3;
	logic [DAY_LO_W-1:0]     lo_s2, lo_s3, lo_s4;
	logic [DAY_X_W+15:0]     p_s2;
	logic [DAYS_W-1:0]       q_s3, days_s4;
	logic [DAYS_W+9:0]       pr_s3;
	logic [9:0]              rr_s4;

	logic [DAYS_W-1:0]       q0;
	logic [DAY_X_W-1:0]      diff;
	logic [10:0]             rc;
	logic [DAYS_W-1:0]       days_n;
	logic [9:0]              rr_n;

	assign q0   = p_s2[DAY_X_W+15:DAY_SHIFT];
	assign diff = x_s3 - pr_s3[DAY_X_W-1:0];
	assign rc   = diff[10:0];

	// estimate is low by at most one
	always_comb begin
		if (rc >= 11'(DAY_ODD)) begin
			days_n = q_s3 + 16'd1;
			rr_n   = 10'(rc - 11'(DAY_ODD));
		end else begin
			days_n = q_s3;
			rr_n   = rc[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= secs[DAY_LO_W+DAY_X_W-1:DAY_LO_W];
			lo_s2   <= secs[DAY_LO_W-1:0];
			p_s2    <= (DAY_X_W+16)'(secs[DAY_LO_W+DAY_X_W-1:DAY_LO_W])
				   * (DAY_X_W+16)'(DAY_RECIP);
			x_s3    <= x_s2;
			lo_s3   <= lo_s2;
			q_s3    <= q0;
			pr_s3   <= (DAYS_W+10)'(q0) * (DAYS_W+10)'(DAY_ODD);
			days_s4 <= days_n;
			rr_s4   <= rr_n;
			lo_s4   <= lo_s3;
		end
	end

	assign days = days_s4;
	assign rem  = {rr_s4, lo_s4};

endmodule

/* rtl/e2c_tod.sv */
// ---------------------------------------------------------------------------
// e2c_tod
// Time of day: seconds of the day to hour, minute and second in four
// stages, two reciprocal divides by sixty with correction.
// ---------------------------------------------------------------------------
module e2c_tod (
	input  logic                         clk,
	input  logic                         en,
	input  logic [e2c_pkg::REM_W-1:0]    rem,
	output logic [e2c_pkg::HOUR_W-1:0]   hour,
	output logic [e2c_pkg::MIN_W-1:0]    minute,
	output logic [e2c_pkg::SEC_W-1:0]    second
);
	import e2c_pkg::*;

	logic [REM_W-1:0]        rem_s5;
	logic [REM_W+11:0]       pm_s5;
	logic [10:0]             mt_s6, mt_s7;
	logic [SEC_W-1:0]        sec_s6, sec_s7, sec_s8;
	logic [16:0]             ph_s7;
	logic [HOUR_W-1:0]       hour_s8;
	logic [MIN_W-1:0]        min_s8;

	logic [11:0]             m0;
	logic [REM_W-1:0]        sdiff;
	logic [6:0]              st;
	logic [10:0]             mt_n;
	logic [SEC_W-1:0]        sec_n;
	logic [5:0]              h0;
	logic [10:0]             mdiff;
	logic [6:0]              mtt;
	logic [HOUR_W-1:0]       hour_n;
	logic [MIN_W-1:0]        min_n;

	assign m0    = pm_s5[REM_W+11:MIN_SHIFT];
	assign sdiff = rem_s5 - REM_W'(m0) * REM_W'(SIXTY);
	assign st    = sdiff[6:0];

	always_comb begin
		if (st >= SIXTY) begin
			mt_n  = 11'(m0) + 11'd1;
			sec_n = 6'(st - SIXTY);
		end else begin
			mt_n  = 11'(m0);
			sec_n = st[5:0];
		end
	end

	assign h0    = ph_s7[16:HR_SHIFT];
	assign mdiff = mt_s7 - 11'(h0) * 11'(SIXTY);
	assign mtt   = mdiff[6:0];

	always_comb begin
		if (mtt >= SIXTY) begin
			hour_n = 5'(h0 + 6'd1);
			min_n  = 6'(mtt - SIXTY);
		end else begin
			hour_n = h0[4:0];
			min_n  = mtt[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5  <= rem;
			pm_s5   <= (REM_W+12)'(rem) * (REM_W+12)'(MIN_RECIP);
			mt_s6   <= mt_n;
			sec_s6  <= sec_n;
			mt_s7   <= mt_s6;
			sec_s7  <= sec_s6;
			ph_s7   <= 17'(mt_s6) * 17'(HR_RECIP);
			hour_s8 <= hour_n;
			min_s8  <= min_n;
			sec_s8  <= sec_s7;
		end
	end

	assign hour   = hour_s8;
	assign minute = min_s8;
	assign second = sec_s8;

endmodule

/* rtl/e2c_date.sv */
// ---------------------------------------------------------------------------
// e2c_date
// Date part: day count to year, month, day of month, day of year and
// weekday in four stages.
// ---------------------------------------------------------------------------
module e2c_date (
	input  logic                         clk,
	input  logic                         en,
	input  logic [e2c_pkg::DAYS_W-1:0]   days,
	output logic [e2c_pkg::YEAR_W-1:0]   year,
	output logic [e2c_pkg::MON_W-1:0]    month,
	output logic [e2c_pkg::MDAY_W-1:0]   mday,
	output logic [e2c_pkg::WDAY_W-1:0]   wday,
	output logic [e2c_pkg::YDAY_W-1:0]   yday
);
	import e2c_pkg::*;

	logic [DAYS_W-1:0]       days_s5, w_s5;
	logic [25:0]             pn_s5;
	logic [29:0]             pw_s5;
	logic [YIDX_W-1:0]       yi_s6;
	logic [YDAY_W-1:0]       yday_s6, yday_s7, yday_s8;
	logic                    leap_s6, leap_s7;
	logic [WDAY_W-1:0]       wd_s6, wd_s7, wd_s8;
	logic [YEAR_W-1:0]       year_s7, year_s8;
	logic [MON_W-1:0]        mon_s7, mon_s8;
	logic [MDAY_W-1:0]       mday_s8;

	logic [DAYS_W-1:0]       wn;
	logic [17:0]             nn;
	logic [YIDX_W-1:0]       i0, i1, yi_n;
	logic [DAYS_W-1:0]       st0, st1, yd_full;
	logic [13:0]             wq;
	logic [DAYS_W-1:0]       wdiff;
	logic [3:0]              wt;
	logic [WDAY_W-1:0]       wd_n;
	logic [MON_W-1:0]        mon_n;
	logic [YDAY_W-1:0]       mday_full;

	assign wn = days + EPOCH_WDAY;
	// year index is floor((4*days + 2) / 1461) over 1970..2099
	assign nn = {days, 2'b10};

	assign i0  = pn_s5[25:YR_SHIFT];
	assign i1  = i0 + 8'd1;
	assign st0 = year_start(i0);
	assign st1 = year_start(i1);

	always_comb begin
		if (days_s5 >= st1) begin
			yi_n    = i1;
			yd_full = days_s5 - st1;
		end else begin
			yi_n    = i0;
			yd_full = days_s5 - st0;
		end
	end

	assign wq    = pw_s5[29:WK_SHIFT];
	assign wdiff = w_s5 - DAYS_W'(wq) * DAYS_W'(DAYS_WEEK);
	assign wt    = wdiff[3:0];

	always_comb begin
		if (wt >= DAYS_WEEK)
			wd_n = 3'(wt - DAYS_WEEK);
		else
			wd_n = wt[2:0];
	end

	// months 1..11 that have already begun
	always_comb begin
		mon_n = '0;
		for (int m = 1; m < 12; m++) begin
			if (yday_s6 >= month_start(MON_W'(m), leap_s6))
				mon_n = mon_n + 4'd1;
		end
	end

	assign mday_full = yday_s7 - month_start(mon_s7, leap_s7) + 9'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			days_s5 <= days;
			w_s5    <= wn;
			pn_s5   <= 26'(nn) * 26'(YR_RECIP);
			pw_s5   <= 30'(wn) * 30'(WK_RECIP);
			yi_s6   <= yi_n;
			yday_s6 <= yd_full[YDAY_W-1:0];
			leap_s6 <= (yi_n[1:0] == 2'd2);
			wd_s6   <= wd_n;
			yday_s7 <= yday_s6;
			leap_s7 <= leap_s6;
			wd_s7   <= wd_s6;
			year_s7 <= yi_s6 + EPOCH_YEAR;
			mon_s7  <= mon_n;
			yday_s8 <= yday_s7;
			wd_s8   <= wd_s7;
			year_s8 <= year_s7;
			mon_s8  <= mon_s7;
			mday_s8 <= mday_full[MDAY_W-1:0];
		end
	end

	assign year  = year_s8;
	assign month = mon_s8;
	assign mday  = mday_s8;
	assign wday  = wd_s8;
	assign yday  = yday_s8;

endmodule

/* verif/calendar_checker.sv */
// ---------------------------------------------------------------------------
// calendar_checker
// Watches both channels of the epoch-seconds to calendar converter, works out
// the calendar fields of every accepted input beat and compares them, field
// by field and in order, with the result beats.
// ---------------------------------------------------------------------------
module calendar_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [e2c_pkg::SECS_W-1:0]    epoch_seconds,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [e2c_pkg::YEAR_W-1:0]    years_since_1900,
	input  logic [e2c_pkg::MON_W-1:0]     month_index,
	input  logic [e2c_pkg::MDAY_W-1:0]    day_of_month,
	input  logic [e2c_pkg::HOUR_W-1:0]    hour_of_day,
	input  logic [e2c_pkg::MIN_W-1:0]     minute_of_hour,
	input  logic [e2c_pkg::SEC_W-1:0]     second_of_minute,
	input  logic [e2c_pkg::WDAY_W-1:0]    weekday,
	input  logic [e2c_pkg::YDAY_W-1:0]    day_of_year,
	input  logic                          out_of_range,
	output int                            error_count,
	output int                            dates_pending
);

	typedef struct packed {
		logic [e2c_pkg::YEAR_W-1:0] year;
		logic [e2c_pkg::MON_W-1:0]  month;
		logic [e2c_pkg::MDAY_W-1:0] mday;
		logic [e2c_pkg::HOUR_W-1:0] hour;
		logic [e2c_pkg::MIN_W-1:0]  minute;
		logic [e2c_pkg::SEC_W-1:0]  second;
		logic [e2c_pkg::WDAY_W-1:0] wday;
		logic [e2c_pkg::YDAY_W-1:0] yday;
		logic                       oor;
	} calendar_t;

	calendar_t expected_dates[$];

	function automatic bit is_leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_length(input int unsigned m,
						     input int unsigned y);
		case (m)
			1:            return is_leap_year(y) ? 29 : 28;
			3, 5, 8, 10:  return 30;
			default:      return 31;
		endcase
	endfunction

	function automatic calendar_t to_calendar(input logic [e2c_pkg::SECS_W-1:0] secs);
		calendar_t        c;
		longint unsigned  s64;
		longint unsigned  days;
		longint unsigned  tod;
		longint unsigned  left;
		longint unsigned  hr;
		longint unsigned  mn;
		longint unsigned  sc;
		longint unsigned  wd;
		int unsigned      yr;
		int unsigned      yoff;
		int unsigned      mon;
		int unsigned      ylen;
		c = '0;
		s64 = 64'(secs);
		if (s64 >= 64'd4102444800) begin
			c.oor = 1'b1;
			return c;
		end
		days = s64 / 86400;
		tod = s64 % 86400;
		left = days;
		yr = 1970;
		// 2099 absorbs whatever is left, as the last valid year
		while (1) begin
			ylen = is_leap_year(yr) ? 366 : 365;
			if (left < ylen || yr + 1 >= 2100)
				break;
			left -= ylen;
			yr++;
		end
		c.yday = left[e2c_pkg::YDAY_W-1:0];
		mon = 0;
		while (mon < 11 && left >= month_length(mon, yr)) begin
			left -= month_length(mon, yr);
			mon++;
		end
		yoff = yr - 1900;
		c.year = yoff[e2c_pkg::YEAR_W-1:0];
		c.month = mon[e2c_pkg::MON_W-1:0];
		left = left + 1;
		c.mday = left[e2c_pkg::MDAY_W-1:0];
		hr = tod / 3600;
		mn = (tod % 3600) / 60;
		sc = tod % 60;
		c.hour = hr[e2c_pkg::HOUR_W-1:0];
		c.minute = mn[e2c_pkg::MIN_W-1:0];
		c.second = sc[e2c_pkg::SEC_W-1:0];
		// the epoch fell on a Thursday
		wd = (days + 4) % 7;
		c.wday = wd[e2c_pkg::WDAY_W-1:0];
		return c;
	endfunction

	function automatic int field_bad(input string name, input int unsigned want,
					 input int unsigned got);
		if (want == got)
			return 0;
		$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		calendar_t want;
		int        errs;
		if (!arst_n) begin
			expected_dates.delete();
			error_count <= 0;
			dates_pending <= 0;
		end else begin
			errs = 0;
			// compare before push so a beat never meets its own expectation
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					$display({"%0t unexpected result beat: expected none, ",
						  "got year %0d mon %0d day %0d oor %0d"},
						 $time, years_since_1900, month_index, day_of_month,
						 out_of_range);
					errs++;
				end else begin
					want = expected_dates.pop_front();
					errs += field_bad("years_since_1900", 32'(want.year),
							  32'(years_since_1900));
					errs += field_bad("month_index", 32'(want.month),
							  32'(month_index));
					errs += field_bad("day_of_month", 32'(want.mday),
							  32'(day_of_month));
					errs += field_bad("hour_of_day", 32'(want.hour),
							  32'(hour_of_day));
					errs += field_bad("minute_of_hour", 32'(want.minute),
							  32'(minute_of_hour));
					errs += field_bad("second_of_minute", 32'(want.second),
							  32'(second_of_minute));
					errs += field_bad("weekday", 32'(want.wday),
							  32'(weekday));
					errs += field_bad("day_of_year", 32'(want.yday),
							  32'(day_of_year));
					errs += field_bad("out_of_range", 32'(want.oor),
							  32'(out_of_range));
				end
			end
			if (in_valid && !in_stall)
				expected_dates.push_back(to_calendar(epoch_seconds));
			error_count <= error_count + errs;
			dates_pending <= expected_dates.size();
		end
	end

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Drives timestamps into the epoch-seconds to calendar converter: calendar
// landmarks first, then random stamps biased toward year and leap-day edges,
// with random gaps and output stalls; the checker judges every result beat.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_STAMPS = 2000;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LONG_HOLD     = 80;

	localparam logic [e2c_pkg::SECS_W-1:0] LANDMARKS [20] = '{
		33'd0,             // epoch
		33'd86399,         // end of first day
		33'd68169599,      // 1972-02-28 23:59:59
		33'd68169600,      // leap day 1972
		33'd68256000,      // 1972-03-01
		33'd94608000,      // 1972-12-31, day of year 365
		33'd94694399,
		33'd946684799,     // last second of 1999
		33'd951782400,     // leap day 2000 (century divisible by 400)
		33'd978307199,     // end of 2000
		33'd2147483647,
		33'd2147483648,
		33'd2863311530,
		33'd4102358400,    // 2099-12-31
		33'd4102444799,    // last valid second
		33'd4102444800,    // first out-of-range second
		33'd4294967295,
		33'd4294967296,
		33'h155555555,
		33'h1FFFFFFFF
	};

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [e2c_pkg::SECS_W-1:0]    epoch_seconds = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [e2c_pkg::YEAR_W-1:0]    years_since_1900;
	logic [e2c_pkg::MON_W-1:0]     month_index;
	logic [e2c_pkg::MDAY_W-1:0]    day_of_month;
	logic [e2c_pkg::HOUR_W-1:0]    hour_of_day;
	logic [e2c_pkg::MIN_W-1:0]     minute_of_hour;
	logic [e2c_pkg::SEC_W-1:0]     second_of_minute;
	logic [e2c_pkg::WDAY_W-1:0]    weekday;
	logic [e2c_pkg::YDAY_W-1:0]    day_of_year;
	logic                          out_of_range;
	int                            error_count;
	int                            dates_pending;
	int                            quiet_cycles = 0;
	bit                            send_gaps = 1'b0;

	epoch_seconds_to_calendar DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.years_since_1900 (years_since_1900),
		.month_index      (month_index),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.weekday          (weekday),
		.day_of_year      (day_of_year),
		.out_of_range     (out_of_range)
	);

	calendar_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.years_since_1900 (years_since_1900),
		.month_index      (month_index),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.weekday          (weekday),
		.day_of_year      (day_of_year),
		.out_of_range     (out_of_range),
		.error_count      (error_count),
		.dates_pending    (dates_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// days from the epoch to January 1 of year y
	function automatic longint unsigned first_day_of(input int unsigned y);
		longint unsigned dn;
		dn = 0;
		for (int unsigned i = 1970; i < y; i++)
			dn += ((i % 4 == 0) && ((i % 100 != 0) || (i % 400 == 0))) ? 366 : 365;
		return dn;
	endfunction

	// stamp near a year start, the end of February or the end of a year
	function automatic logic [e2c_pkg::SECS_W-1:0] edge_stamp();
		longint unsigned dn;
		longint unsigned off;
		longint unsigned back;
		longint unsigned s64;
		longint unsigned tod;
		dn = first_day_of($urandom_range(2099, 1970));
		case ($urandom_range(5, 0))
			0:       off = 0;
			1:       off = 58;
			2:       off = 59;
			3:       off = 60;
			4:       off = 364;
			default: off = 365;
		endcase
		back = 64'($urandom_range(1, 0));
		if (dn + off >= back)
			dn = dn + off - back;
		case ($urandom_range(2, 0))
			0:       tod = 0;
			1:       tod = 86399;
			default: tod = 64'($urandom_range(86399, 0));
		endcase
		s64 = dn * 86400 + tod;
		if (s64 >= 64'd4102444800)
			s64 = 64'd4102444799;
		return s64[e2c_pkg::SECS_W-1:0];
	endfunction

	task automatic send_stamp(input logic [e2c_pkg::SECS_W-1:0] secs);
		int gap;
		gap = send_gaps ? $urandom_range(6, 0) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= secs;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (dates_pending != 0)
			@(posedge clk);
	endtask

	// sender
	initial begin
		logic [e2c_pkg::SECS_W-1:0] secs;
		int                         pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (LANDMARKS[i])
			send_stamp(LANDMARKS[i]);
		for (int n = 0; n < RANDOM_STAMPS; n++) begin
			if (n % 150 == 0)
				send_gaps = ($urandom_range(3, 0) != 0);
			if (n == 700 || n == 1500) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			pick = $urandom_range(99, 0);
			if (pick < 55)
				secs = {1'b0, $urandom()} % e2c_pkg::END_SECONDS;
			else if (pick < 80)
				secs = edge_stamp();
			else if (pick < 90)
				secs = {1'b0, $urandom()};
			else
				secs = {1'($urandom_range(1, 0)), $urandom()};
			send_stamp(secs);
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && dates_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: per-beat random stall, two long holds to back up the pipeline
	initial begin
		int  hold;
		int  beats;
		bit  stalls_on;
		beats = 0;
		stalls_on = 1'b0;
		forever begin
			if (beats % 150 == 0)
				stalls_on = ($urandom_range(3, 0) != 0);
			if (beats == 300 || beats == 1300)
				hold = LONG_HOLD;
			else
				hold = stalls_on ? $urandom_range(6, 0) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			beats++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

/* sim.f */
rtl/e2c_pkg.sv
rtl/e2c_day_div.sv
rtl/e2c_tod.sv
rtl/e2c_date.sv
rtl/epoch_seconds_to_calendar.sv
verif/calendar_checker.sv
verif/tb_top.sv
